// ----- rtl/irt_pkg.sv -----
// shared constants and helpers for the integer to radix text converter
// no dependencies; used by every module under rtl
`default_nettype none

package irt_pkg;

   localparam int unsigned MAX_RADIX   = 16;
   localparam int unsigned MAX_DIGITS  = 32;
   localparam int unsigned DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int unsigned CNT_W       = DIGIT_IDX_W + 1;
   localparam int unsigned STEP_BITS   = 8;

   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;

   // register indexes on the csr port
   localparam logic [1:0] REG_RADIX    = 2'd0;
   localparam logic [1:0] REG_SYM_LOW  = 2'd1;
   localparam logic [1:0] REG_SYM_HIGH = 2'd2;

   // pick one alphabet byte out of the two symbol registers
   function automatic logic [7:0] symbol_at(input logic [63:0] sym_low,
                                            input logic [63:0] sym_high,
                                            input logic [3:0]  idx);
      logic [63:0] word;
      word = idx[3] ? sym_high : sym_low;
      symbol_at = word[{idx[2:0], 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/irt_div_step.sv -----
// shared divide unit: eight restoring long-division steps by the radix
// depends on irt_pkg
`default_nettype none

module irt_div_step (
   input  wire logic [4:0]                    radix,
   input  wire logic [3:0]                    rem_in,
   input  wire logic [irt_pkg::STEP_BITS-1:0] bits_in,
   output logic [irt_pkg::STEP_BITS-1:0]      quot_out,
   output logic [3:0]                         rem_out
);

   always_comb begin
      logic [3:0] rem;
      logic [4:0] trial;
      rem = rem_in;
      quot_out = '0;
      // msb first, remainder stays below the radix
      for (int k = irt_pkg::STEP_BITS - 1; k >= 0; k--) begin
         trial = {rem, bits_in[k]};
         if (trial >= radix) begin
            quot_out[k] = 1'b1;
            rem = 4'(trial - radix);
         end else begin
            rem = trial[3:0];
         end
      end
      rem_out = rem;
   end

endmodule

`default_nettype wire

// ----- rtl/irt_alpha_check.sv -----
// alphabet check for one symbol position against all later symbols in use
// depends on irt_pkg
`default_nettype none

module irt_alpha_check #(
   parameter int unsigned MAX_RADIX = irt_pkg::MAX_RADIX
) (
   input  wire logic [4:0]  radix,
   input  wire logic [63:0] sym_low,
   input  wire logic [63:0] sym_high,
   input  wire logic [3:0]  idx,
   output logic             bad
);

   logic [7:0] sym_i;
   logic       dup;
   logic       range_bad;

   assign sym_i     = irt_pkg::symbol_at(sym_low, sym_high, idx);
   assign range_bad = (radix < 5'd2) || (radix > 5'(MAX_RADIX));

   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < 16; j++) begin
         if ((5'(j) > {1'b0, idx}) && (5'(j) < radix) &&
             (irt_pkg::symbol_at(sym_low, sym_high, 4'(j)) == sym_i)) begin
            dup = 1'b1;
         end
      end
   end

   assign bad = range_bad || dup ||
                (sym_i == irt_pkg::SYM_PLUS) || (sym_i == irt_pkg::SYM_MINUS);

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_text.sv -----
// top level of the integer to radix text converter: sequencer, csr block, digit store
// depends on irt_pkg, irt_alpha_check, irt_div_step
`default_nettype none

// usage
//   a transaction on the request side is taken when start is high and busy is low;
//   req_value is a signed 32-bit number. busy stays high until the whole text is out.
//   the text leaves as one byte per cycle on rsp_symbol, marked by rsp_valid,
//   most significant symbol first, with a leading '-' for negative numbers.
//   rsp_last flags the final symbol. the receiver cannot stall: each byte is
//   shown for exactly one cycle.
//   the alphabet (radix, symbols_low, symbols_high) sits behind the apb port at
//   byte addresses 0, 8 and 16; write it only while busy is low.
//   a bad alphabet (radix outside 2..16, a '+' or '-' symbol, a repeated symbol)
//   makes the transaction produce no bytes.
// sequence
//   accept, then an alphabet check of each symbol in use in turn, then the shared
//   divide unit, one pass over the magnitude per digit (8 quotient bits a cycle),
//   then the emitted bytes. the divide unit is the limit on rate.
// reset
//   synchronous, clears the sequencer, the csr registers and the output strobe.

module integer_to_radix_text #(
   parameter int unsigned MAX_RADIX  = irt_pkg::MAX_RADIX,
   parameter int unsigned MAX_DIGITS = irt_pkg::MAX_DIGITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        start,
   output logic             busy,
   input  wire logic signed [31:0] req_value,
   // result side
   output logic             rsp_valid,
   output logic [7:0]       rsp_symbol,
   output logic             rsp_last,
   // csr port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
   localparam int unsigned CNT_W = IDX_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_SIGN,
      S_EMIT
   } state_type;

   // csr registers
   logic [4:0]  radix_ff;
   logic [63:0] sym_low_ff;
   logic [63:0] sym_high_ff;
   logic        csr_wr;

   // sequencer and datapath registers
   state_type        state_ff, state_in;
   logic [31:0]      mag_ff, mag_in;
   logic [3:0]       rem_ff, rem_in;
   logic [1:0]       step_ff, step_in;
   logic [3:0]       idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sign_ff, sign_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_symbol_ff, rsp_symbol_in;
   logic             rsp_last_ff, rsp_last_in;

   // digit store, least significant digit first
   logic [3:0]       store_ff [MAX_DIGITS];
   logic             store_wr;

   // shared unit connections
   logic [irt_pkg::STEP_BITS-1:0] quot;
   logic [3:0]                    rem_step;
   logic                          alpha_bad;
   logic [CNT_W-1:0]              cnt_dec;
   logic [31:0]                   raw;
   logic                          accept;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[4:3])
            irt_pkg::REG_RADIX:    radix_ff    <= pwdata[4:0];
            irt_pkg::REG_SYM_LOW:  sym_low_ff  <= pwdata;
            irt_pkg::REG_SYM_HIGH: sym_high_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:3])
         irt_pkg::REG_RADIX:    prdata = {59'd0, radix_ff};
         irt_pkg::REG_SYM_LOW:  prdata = sym_low_ff;
         irt_pkg::REG_SYM_HIGH: prdata = sym_high_ff;
         default:               prdata = '0;
      endcase
   end

   // shared units
   irt_alpha_check #(
      .MAX_RADIX (MAX_RADIX)
   ) u_alpha (
      .radix    (radix_ff),
      .sym_low  (sym_low_ff),
      .sym_high (sym_high_ff),
      .idx      (idx_ff),
      .bad      (alpha_bad)
   );

   irt_div_step u_div (
      .radix    (radix_ff),
      .rem_in   (rem_ff),
      .bits_in  (mag_ff[31 -: irt_pkg::STEP_BITS]),
      .quot_out (quot),
      .rem_out  (rem_step)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign raw     = req_value;
   assign cnt_dec = cnt_ff - CNT_W'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      sign_in       = sign_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = 1'b0;
      store_wr      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // magnitude as unsigned, so the most negative value survives
               sign_in  = raw[31];
               mag_in   = raw[31] ? (32'd0 - raw) : raw;
               idx_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (alpha_bad) begin
               state_in = S_IDLE;
            end else if ({1'b0, idx_ff} == (radix_ff - 5'd1)) begin
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         S_DIV: begin
            // one quotient byte per cycle, quotient shifts in behind the dividend
            mag_in  = {mag_ff[31-irt_pkg::STEP_BITS:0], quot};
            rem_in  = rem_step;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               store_wr = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               rem_in   = '0;
               if (mag_in == 32'd0) begin
                  state_in = sign_ff ? S_SIGN : S_EMIT;
               end
            end
         end
         S_SIGN: begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = irt_pkg::SYM_MINUS;
            rsp_last_in   = 1'b0;
            sign_in       = 1'b0;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = irt_pkg::symbol_at(sym_low_ff, sym_high_ff,
                                               store_ff[cnt_dec[IDX_W-1:0]]);
            rsp_last_in   = (cnt_ff == CNT_W'(1));
            cnt_in        = cnt_dec;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mag_ff        <= '0;
         rem_ff        <= '0;
         step_ff       <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         sign_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_symbol_ff <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mag_ff        <= mag_in;
         rem_ff        <= rem_in;
         step_ff       <= step_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         sign_ff       <= sign_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_symbol_ff <= rsp_symbol_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[cnt_ff[IDX_W-1:0]] <= rem_step;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // checks
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (cnt_ff != '0))
      else $error("emit with empty digit store");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ({1'b0, rem_ff} < radix_ff))
      else $error("division remainder not below radix");

   a_last_ends_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("final symbol while sequencer still active");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_symbol_ff == irt_pkg::SYM_MINUS)) |-> !rsp_last_ff)
      else $error("sign symbol marked as final");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire

// ----- dv/tb_integer_to_radix_text.sv -----
// testbench for integer_to_radix_text: directed and random checks of the text output
// depends on irt_pkg and rtl/integer_to_radix_text.sv; predicts every character itself
`default_nettype none

module tb_integer_to_radix_text;

   // margin above the longest transaction: accept, a 16-symbol check, divide of 32 digits, 33 bytes
   localparam int SETTLE_CYCLES = 200;

   // one character of the converted text as it leaves on the result side
   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_symbol;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // our own copy of the alphabet registers, updated as each write lands
   logic [4:0]  cfg_radix = '0;
   logic [63:0] cfg_sym_low = '0;
   logic [63:0] cfg_sym_high = '0;

   text_char_type pending_text[$];   // characters predicted but not yet seen
   text_char_type oldest;
   int          failures = 0;
   bit          no_idle = 1'b0;    // set for the long stretch without gaps
   int          counted_items = 0; // transactions on a valid alphabet in the random part

   integer_to_radix_text i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // the text the block should produce for one number under the current alphabet
   function automatic void predict_text(input logic [31:0] value);
      logic [127:0] table_bits;
      logic [31:0]  mag;
      logic [3:0]   digits[32];
      logic [7:0]   a;
      bit           usable;
      int           n;
      int           i;
      int           j;
      table_bits = {cfg_sym_high, cfg_sym_low};
      usable = (cfg_radix >= 2) && (cfg_radix <= irt_pkg::MAX_RADIX);
      // alphabet check: no sign symbols and no repeats among the symbols in use
      for (i = 0; usable && i < int'(cfg_radix); i++) begin
         a = table_bits[8*i +: 8];
         if (a == irt_pkg::SYM_PLUS || a == irt_pkg::SYM_MINUS)
            usable = 1'b0;
         for (j = i + 1; j < int'(cfg_radix); j++)
            if (table_bits[8*j +: 8] == a)
               usable = 1'b0;
      end
      if (!usable)
         return;
      // unsigned magnitude so the most negative value needs no 33rd bit
      mag = value[31] ? (32'd0 - value) : value;
      n = 0;
      do begin
         digits[n] = 4'(mag % cfg_radix);
         mag = mag / cfg_radix;
         n++;
      end while (mag != 0);
      if (value[31])
         pending_text.push_back('{symbol: irt_pkg::SYM_MINUS, last: 1'b0});
      for (i = n - 1; i >= 0; i--)
         pending_text.push_back('{symbol: table_bits[8*int'(digits[i]) +: 8],
                                  last: (i == 0)});
   endfunction

   // one transaction on the request side, at times with a random gap in front of it
   task automatic send_value(input logic [31:0] value);
      if (!no_idle && $urandom_range(0, 99) < 34) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      // taken at the edge where start is high and busy is low
      do @(posedge clock); while (busy);
      predict_text(value);
   endtask

   // let every predicted character come out, then let a silent transaction finish
   task automatic drain_results();
      start <= 1'b0;
      while (pending_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup phase, access phase, then back to idle
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         irt_pkg::REG_RADIX:    cfg_radix    = data[4:0];
         irt_pkg::REG_SYM_LOW:  cfg_sym_low  = data;
         irt_pkg::REG_SYM_HIGH: cfg_sym_high = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_alphabet(input logic [4:0] radix, input logic [63:0] sym_low,
                               input logic [63:0] sym_high);
      drain_results();
      write_reg(irt_pkg::REG_RADIX, 64'(radix));
      write_reg(irt_pkg::REG_SYM_LOW, sym_low);
      write_reg(irt_pkg::REG_SYM_HIGH, sym_high);
   endtask

   // random 16-byte table whose first radix symbols are distinct and sign free
   task automatic make_table(input int radix, output logic [63:0] sym_low,
                             output logic [63:0] sym_high);
      logic [127:0] table_bits;
      logic [7:0]   b;
      bit           clash;
      int           i;
      int           j;
      for (i = 0; i < 16; i++) begin
         do begin
            b = 8'($urandom);
            clash = (i < radix) && (b == irt_pkg::SYM_PLUS || b == irt_pkg::SYM_MINUS);
            for (j = 0; j < i && i < radix; j++)
               if (table_bits[8*j +: 8] == b)
                  clash = 1'b1;
         end while (clash);
         table_bits[8*i +: 8] = b;
      end
      sym_low  = table_bits[63:0];
      sym_high = table_bits[127:64];
   endtask

   // mix of full-width, short, small and extreme numbers of either sign
   function automatic logic [31:0] random_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5: begin
            v = $urandom_range(0, 300);
            if ($urandom_range(0, 1))
               v = -v;
         end
         6: begin
            case ($urandom_range(0, 4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   // every strobed byte is matched against the oldest predicted character
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_text.size() == 0) begin
            $error("unexpected character: symbol %h last %b", rsp_symbol, rsp_last);
            failures++;
         end else begin
            oldest = pending_text.pop_front();
            if (rsp_symbol !== oldest.symbol) begin
               $error("symbol: expected %h, got %h", oldest.symbol, rsp_symbol);
               failures++;
            end
            if (rsp_last !== oldest.last) begin
               $error("last: expected %b, got %b", oldest.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // radix 0 out of reset: nothing may come out
   task automatic test_after_reset();
      send_value(32'd5);
      send_value(32'hFFFF_FFF0);
   endtask

   // decimal, with '+' and '-' parked in the unused bytes
   task automatic test_decimal();
      set_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h2D2B_2D2B_2D2B_3938);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFF6);
   endtask

   // full sixteen-symbol alphabet
   task automatic test_hex();
      set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
   endtask

   // binary with a zero byte as a real symbol; repeats in unused bytes are fine
   task automatic test_binary_zero_byte();
      set_alphabet(5'd2, 64'h0000_0000_0000_FF00, 64'h0);
      send_value(32'h8000_0000);   // longest text: sign plus 32 digits
      send_value(32'hFFFF_FFFF);
      send_value(32'd0);
   endtask

   // each broken alphabet swallows the transaction
   task automatic test_bad_alphabets();
      set_alphabet(5'd1, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
      send_value(32'd7);
      set_alphabet(5'd17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
      send_value(32'd7);
      set_alphabet(5'd31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
      send_value(32'hFFFF_FF00);
      // '+' as symbol 3
      set_alphabet(5'd10, 64'h3736_3534_2B32_3130, 64'h0000_0000_0000_3938);
      send_value(32'd123);
      // '-' as the last symbol in use
      set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938);
      send_value(32'd123);
      // symbol 15 repeats symbol 0
      set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938);
      send_value(32'hDEAD_BEEF);
   endtask

   // random alphabets, mostly valid, with the extreme radices weighted up
   task automatic test_random_phases();
      logic [63:0] sym_low;
      logic [63:0] sym_high;
      logic [127:0] table_bits;
      int radix;
      int phase;
      int n_items;
      int p;
      int q;
      int k;
      phase = 0;
      while (counted_items < 360) begin
         if (phase != 4 && $urandom_range(0, 5) == 0) begin
            // broken alphabet phase: a few transactions that produce nothing
            radix = $urandom_range(2, 16);
            make_table(radix, sym_low, sym_high);
            table_bits = {sym_high, sym_low};
            p = $urandom_range(1, radix - 1);
            case ($urandom_range(0, 3))
               0: radix = $urandom_range(0, 1);
               1: radix = $urandom_range(17, 31);
               2: table_bits[8*p +: 8] = $urandom_range(0, 1) ? irt_pkg::SYM_PLUS
                                                              : irt_pkg::SYM_MINUS;
               default: begin
                  q = $urandom_range(0, p - 1);
                  table_bits[8*p +: 8] = table_bits[8*q +: 8];
               end
            endcase
            set_alphabet(5'(radix), table_bits[63:0], table_bits[127:64]);
            for (k = 0; k < 3; k++)
               send_value(random_value());
         end else begin
            case ($urandom_range(0, 3))
               0: radix = 2;
               1: radix = 16;
               default: radix = $urandom_range(3, 15);
            endcase
            make_table(radix, sym_low, sym_high);
            set_alphabet(5'(radix), sym_low, sym_high);
            // one long phase runs back to back with no gaps at all
            no_idle = (phase == 4);
            n_items = no_idle ? 40 : $urandom_range(15, 35);
            for (k = 0; k < n_items; k++) begin
               send_value(random_value());
               counted_items++;
            end
            no_idle = 1'b0;
         end
         phase++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_decimal();
      test_hex();
      test_binary_zero_byte();
      test_bad_alphabets();
      test_random_phases();
      // everything predicted must arrive, and nothing after it
      drain_results();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
